### src/pidtd_pkg.sv
package pidtd_pkg;

  // Magnitude width of every product and quotient; products saturate at 2^60.
  localparam int MAG_W = 61;
  localparam logic [MAG_W-1:0] PROD_LIM = {1'b1, {(MAG_W-1){1'b0}}};

  // Width of an operation length, enough to hold a count of 64 bits.
  localparam int LEN_W = 7;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  // Request from the sequencer to the shared arithmetic unit.
  typedef struct packed {
    logic             start;
    unit_op_t         op;
    logic [LEN_W-1:0] len;
  } unit_req_t;

endpackage

### src/pid_controller_two_derivative.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_measured, in_target, in_now_us
// out      output     out_valid / out_ready  out_drive, out_fresh
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time: in_ready is high only while the sequencer is idle.
// A repeated step returns the last drive; a first step runs only the proportional term.
// A full step runs six multiplies and three divides through one shared
// bit-serial unit, one bit a cycle; with smoothing zero, one multiply and
// one divide are skipped.
// The result sits in an output register; a stalled out_ready holds the
// sequencer before it returns to idle. Reset is synchronous and clears all
// controller state and configuration; cfg_ready is always high.
module pid_controller_two_derivative #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH   = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_measured,
  input  logic signed [SAMPLE_WIDTH-1:0] in_target,
  input  logic [TIME_WIDTH-1:0]          in_now_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_drive,
  output logic                           out_fresh,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);
  import pidtd_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int TW     = TIME_WIDTH;
  localparam int SUM_W  = 64;
  localparam int THR_W  = 27;
  localparam int OPB_W  = (TW > MAG_W) ? TW : MAG_W;
  localparam logic [LEN_W-1:0] LEN_ERR   = LEN_W'(SW + 1);
  localparam logic [LEN_W-1:0] LEN_EDIFF = LEN_W'(SW + 2);
  localparam logic [LEN_W-1:0] LEN_D8    = LEN_W'(SW + 9);
  localparam logic [LEN_W-1:0] LEN_SMTH  = LEN_W'(16);
  localparam logic [LEN_W-1:0] LEN_DT    = LEN_W'(TW);
  localparam logic [LEN_W-1:0] LEN_DIV   = LEN_W'(MAG_W);

  typedef enum logic [2:0] {
    CFG_KP, CFG_KI, CFG_KD, CFG_KM, CFG_LOW, CFG_HIGH, CFG_MCYC, CFG_SMOOTH
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_P, S_KIE, S_INC, S_INTEG, S_ADDI, S_ED, S_EDDIV,
    S_D8, S_SMUL, S_SDIV, S_MD, S_MDDIV, S_FIN, S_OUT
  } state_t;

  function automatic logic signed [SUM_W-1:0] apply_sign(
    input logic [MAG_W-1:0] m, input logic neg);
    logic signed [SUM_W-1:0] v;
    v = signed'(SUM_W'(m));
    return neg ? -v : v;
  endfunction

  // Control, configuration and controller state
  state_t                  state_r, state_nxt;
  logic                    issued_r, issued_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]    out_drive_r, out_drive_nxt;
  logic                    out_fresh_r, out_fresh_nxt;
  logic signed [31:0]      kp_r, kp_nxt, ki_r, ki_nxt, kd_r, kd_nxt, km_r, km_nxt;
  logic signed [SW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [15:0]             mcyc_r, mcyc_nxt, smooth_r, smooth_nxt;
  logic signed [SW+15:0]   integ_r, integ_nxt;
  logic signed [SW:0]      perr_r, perr_nxt;
  logic signed [SW-1:0]    pmeas_r, pmeas_nxt;
  logic signed [SW+8:0]    pdelta_r, pdelta_nxt;
  logic signed [SW-1:0]    pdrive_r, pdrive_nxt;
  logic [TW-1:0]           ptime_r, ptime_nxt;
  logic                    has_run_r, has_run_nxt;

  // Per-word working registers
  logic signed [SW-1:0]    meas_r, meas_nxt;
  logic [TW-1:0]           now_r, now_nxt;
  logic [TW-1:0]           dt_r, dt_nxt;
  logic signed [SW:0]      err_r, err_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [MAG_W-1:0]        tmag_r, tmag_nxt;
  logic                    tneg_r, tneg_nxt;
  logic signed [SUM_W-1:0] tsig_r, tsig_nxt;
  logic signed [SUM_W-1:0] num_r, num_nxt;
  logic signed [SW+8:0]    d8_r, d8_nxt;
  logic signed [SW-1:0]    res_drive_r, res_drive_nxt;
  logic                    res_fresh_r, res_fresh_nxt;

  // Shared unit hookup
  unit_req_t               req;
  logic [MAG_W-1:0]        ua;
  logic [OPB_W-1:0]        ub;
  logic [TW-1:0]           udvs;
  logic                    unit_done;
  logic [MAG_W-1:0]        unit_res;
  logic                    op_state;
  logic                    op_done;

  // Derived values
  logic [31:0]             kp_mag, ki_mag, kd_mag, km_mag;
  logic [SW:0]             err_mag;
  logic signed [SW+1:0]    ediff;
  logic [SW+1:0]           ediff_mag;
  logic signed [SW+8:0]    d8_raw;
  logic [SW+8:0]           d8_mag;
  logic [SW+8:0]           sm_mag;
  logic [SUM_W-1:0]        num_mag;
  logic [THR_W-1:0]        thr;
  logic signed [SUM_W-1:0] integ_sum, integ_c1, integ_c2, hi_q, lo_q;
  logic signed [SUM_W-1:0] drv_full, drv_c1, drv_c2, hi_x, lo_x;

  assign kp_mag    = kp_r[31] ? (~kp_r + 1'b1) : kp_r;
  assign ki_mag    = ki_r[31] ? (~ki_r + 1'b1) : ki_r;
  assign kd_mag    = kd_r[31] ? (~kd_r + 1'b1) : kd_r;
  assign km_mag    = km_r[31] ? (~km_r + 1'b1) : km_r;
  assign err_mag   = err_r[SW] ? (~err_r + 1'b1) : err_r;
  assign ediff     = (SW+2)'(err_r) - (SW+2)'(perr_r);
  assign ediff_mag = ediff[SW+1] ? (~ediff + 1'b1) : ediff;
  assign d8_raw    = ((SW+9)'(meas_r) - (SW+9)'(pmeas_r)) <<< 8;
  assign d8_mag    = d8_r[SW+8] ? (~d8_r + 1'b1) : d8_r;
  assign sm_mag    = tsig_r[SUM_W-1] ? (~tsig_r[SW+8:0] + 1'b1) : tsig_r[SW+8:0];
  assign num_mag   = num_r[SUM_W-1] ? (~num_r + 1'b1) : num_r;
  assign thr       = THR_W'({1'b0, mcyc_r} + 17'd1) * THR_W'(1000);

  // Integral clamp: high bound first, low bound wins
  assign hi_q      = SUM_W'(hi_r) <<< 16;
  assign lo_q      = SUM_W'(lo_r) <<< 16;
  assign integ_sum = SUM_W'(integ_r) + tsig_r;
  assign integ_c1  = (integ_sum > hi_q) ? hi_q : integ_sum;
  assign integ_c2  = (integ_c1 < lo_q) ? lo_q : integ_c1;

  // Output: floor of the Q.16 sum, then clamp
  assign hi_x      = SUM_W'(hi_r);
  assign lo_x      = SUM_W'(lo_r);
  assign drv_full  = sum_r >>> 16;
  assign drv_c1    = (drv_full > hi_x) ? hi_x : drv_full;
  assign drv_c2    = (drv_c1 < lo_x) ? lo_x : drv_c1;

  assign op_done   = issued_r && unit_done;

  pidtd_unit #(
    .OPB_W (OPB_W),
    .DVS_W (TW)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (ua),
    .b     (ub),
    .dvs   (udvs),
    .done  (unit_done),
    .res   (unit_res)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    out_fresh_nxt = out_fresh_r;
    kp_nxt = kp_r; ki_nxt = ki_r; kd_nxt = kd_r; km_nxt = km_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mcyc_nxt = mcyc_r; smooth_nxt = smooth_r;
    integ_nxt   = integ_r;
    perr_nxt    = perr_r;
    pmeas_nxt   = pmeas_r;
    pdelta_nxt  = pdelta_r;
    pdrive_nxt  = pdrive_r;
    ptime_nxt   = ptime_r;
    has_run_nxt = has_run_r;
    meas_nxt = meas_r; now_nxt = now_r; dt_nxt = dt_r; err_nxt = err_r;
    sum_nxt  = sum_r; tmag_nxt = tmag_r; tneg_nxt = tneg_r; tsig_nxt = tsig_r;
    num_nxt  = num_r; d8_nxt = d8_r;
    res_drive_nxt = res_drive_r;
    res_fresh_nxt = res_fresh_r;
    req.op  = OP_MUL;
    req.len = LEN_ERR;
    ua      = '0;
    ub      = '0;
    udvs    = '0;
    op_state = 1'b0;

    // Write configuration registers
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:     kp_nxt     = cfg_data;
        CFG_KI:     ki_nxt     = cfg_data;
        CFG_KD:     kd_nxt     = cfg_data;
        CFG_KM:     km_nxt     = cfg_data;
        CFG_LOW:    lo_nxt     = cfg_data[SW-1:0];
        CFG_HIGH:   hi_nxt     = cfg_data[SW-1:0];
        CFG_MCYC:   mcyc_nxt   = cfg_data[15:0];
        CFG_SMOOTH: smooth_nxt = cfg_data[15:0];
        default:    ;
      endcase
    end

    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          meas_nxt  = in_measured;
          now_nxt   = in_now_us;
          dt_nxt    = in_now_us - ptime_r;
          err_nxt   = (SW+1)'(in_target) - (SW+1)'(in_measured);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dt_r >= TW'(thr)) begin
          state_nxt = S_P;
        end else begin
          res_drive_nxt = pdrive_r;
          res_fresh_nxt = 1'b0;
          state_nxt     = S_OUT;
        end
      end
      S_P: begin
        op_state = 1'b1;
        ua = MAG_W'(kp_mag);
        ub = OPB_W'(err_mag);
        if (op_done) begin
          sum_nxt   = apply_sign(unit_res, kp_r[31] ^ err_r[SW]);
          state_nxt = has_run_r ? S_KIE : S_FIN;
        end
      end
      S_KIE: begin
        op_state = 1'b1;
        ua = MAG_W'(ki_mag);
        ub = OPB_W'(err_mag);
        if (op_done) begin
          tmag_nxt  = unit_res;
          tneg_nxt  = ki_r[31] ^ err_r[SW];
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        op_state = 1'b1;
        req.len  = LEN_DT;
        ua = tmag_r;
        ub = OPB_W'(dt_r);
        if (op_done) begin
          tsig_nxt  = apply_sign(unit_res, tneg_r);
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        integ_nxt = integ_c2[SW+15:0];
        state_nxt = S_ADDI;
      end
      S_ADDI: begin
        sum_nxt   = sum_r + SUM_W'(integ_r);
        state_nxt = S_ED;
      end
      S_ED: begin
        op_state = 1'b1;
        req.len  = LEN_EDIFF;
        ua = MAG_W'(kd_mag);
        ub = OPB_W'(ediff_mag);
        if (op_done) begin
          tmag_nxt  = unit_res;
          tneg_nxt  = kd_r[31] ^ ediff[SW+1];
          state_nxt = S_EDDIV;
        end
      end
      S_EDDIV: begin
        op_state = 1'b1;
        req.op   = OP_DIV;
        req.len  = LEN_DIV;
        ub   = OPB_W'(tmag_r);
        udvs = dt_r;
        if (op_done) begin
          sum_nxt   = sum_r + apply_sign(unit_res, tneg_r);
          state_nxt = S_D8;
        end
      end
      S_D8: begin
        d8_nxt = d8_raw;
        if (smooth_r != '0) begin
          state_nxt = S_SMUL;
        end else begin
          pdelta_nxt = d8_raw;
          state_nxt  = S_MD;
        end
      end
      S_SMUL: begin
        op_state = 1'b1;
        req.len  = LEN_SMTH;
        ua = MAG_W'(d8_mag);
        ub = OPB_W'(smooth_r);
        if (op_done) begin
          num_nxt   = (SUM_W'(pdelta_r) <<< 8) + apply_sign(unit_res, d8_r[SW+8]);
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        op_state = 1'b1;
        req.op   = OP_DIV;
        req.len  = LEN_DIV;
        ub   = OPB_W'(num_mag[MAG_W-1:0]);
        udvs = TW'({1'b0, smooth_r} + 17'd256);
        if (op_done) begin
          tsig_nxt  = apply_sign(unit_res, num_r[SUM_W-1]);
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        op_state = 1'b1;
        req.len  = LEN_D8;
        ua = MAG_W'(km_mag);
        ub = OPB_W'(d8_mag);
        // Take the smoothed delta on entry from the divide
        if (!issued_r && smooth_r != '0) begin
          ub = OPB_W'(sm_mag);
          d8_nxt     = tsig_r[SW+8:0];
          pdelta_nxt = tsig_r[SW+8:0];
        end
        if (op_done) begin
          tmag_nxt  = unit_res;
          tneg_nxt  = km_r[31] ^ d8_r[SW+8];
          state_nxt = S_MDDIV;
        end
      end
      S_MDDIV: begin
        op_state = 1'b1;
        req.op   = OP_DIV;
        req.len  = LEN_DIV;
        ub   = OPB_W'(tmag_r);
        udvs = dt_r;
        if (op_done) begin
          sum_nxt   = sum_r - apply_sign(unit_res >> 8, tneg_r);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_drive_nxt = drv_c2[SW-1:0];
        res_fresh_nxt = 1'b1;
        pdrive_nxt    = drv_c2[SW-1:0];
        perr_nxt      = err_r;
        pmeas_nxt     = meas_r;
        ptime_nxt     = now_r;
        has_run_nxt   = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_drive_r;
          out_fresh_nxt = res_fresh_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Pulse start once per operation, then wait for done
    req.start  = op_state && !issued_r;
    issued_nxt = op_state && !op_done;
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_drive_r <= '0;
      out_fresh_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      km_r        <= '0;
      lo_r        <= {1'b1, {(SW-1){1'b0}}};
      hi_r        <= {1'b0, {(SW-1){1'b1}}};
      mcyc_r      <= '0;
      smooth_r    <= '0;
      integ_r     <= '0;
      perr_r      <= '0;
      pmeas_r     <= '0;
      pdelta_r    <= '0;
      pdrive_r    <= '0;
      ptime_r     <= '0;
      has_run_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      out_drive_r <= out_drive_nxt;
      out_fresh_r <= out_fresh_nxt;
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      km_r        <= km_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      mcyc_r      <= mcyc_nxt;
      smooth_r    <= smooth_nxt;
      integ_r     <= integ_nxt;
      perr_r      <= perr_nxt;
      pmeas_r     <= pmeas_nxt;
      pdelta_r    <= pdelta_nxt;
      pdrive_r    <= pdrive_nxt;
      ptime_r     <= ptime_nxt;
      has_run_r   <= has_run_nxt;
    end
  end

  // Advance the working registers of the current word
  always_ff @(posedge clk) begin
    meas_r      <= meas_nxt;
    now_r       <= now_nxt;
    dt_r        <= dt_nxt;
    err_r       <= err_nxt;
    sum_r       <= sum_nxt;
    tmag_r      <= tmag_nxt;
    tneg_r      <= tneg_nxt;
    tsig_r      <= tsig_nxt;
    num_r       <= num_nxt;
    d8_r        <= d8_nxt;
    res_drive_r <= res_drive_nxt;
    res_fresh_r <= res_fresh_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_fresh = out_fresh_r;
  assign cfg_ready = 1'b1;

endmodule

### src/pidtd_unit.sv
module pidtd_unit #(
  parameter int OPB_W = 64,
  parameter int DVS_W = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pidtd_pkg::unit_req_t        req,
  input  logic [pidtd_pkg::MAG_W-1:0] a,
  input  logic [OPB_W-1:0]            b,
  input  logic [DVS_W-1:0]            dvs,
  output logic                        done,
  output logic [pidtd_pkg::MAG_W-1:0] res
);
  import pidtd_pkg::*;

  localparam int IDX_W = $clog2(OPB_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  unit_op_t           op_r, op_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [MAG_W-1:0]   a_r, a_nxt;
  logic [OPB_W-1:0]   b_r, b_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [MAG_W-1:0]   acc_r, acc_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;

  logic               bit_cur;
  logic [MAG_W+1:0]   msum;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     tdiff;
  logic               q_bit;

  // Current operand bit, most significant first
  assign bit_cur = b_r[cnt_r];

  // Multiply step: double and add, pinned at the product limit
  assign msum = {1'b0, acc_r, 1'b0} + (MAG_W+2)'(bit_cur ? a_r : '0);

  // Divide step: restoring trial subtract
  assign trial = {rem_r, bit_cur};
  assign tdiff = trial - {1'b0, dvs_r};
  assign q_bit = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    dvs_nxt  = dvs_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      // Load operands and clear the accumulators
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = IDX_W'(req.len - LEN_W'(1));
      a_nxt    = a;
      b_nxt    = b;
      dvs_nxt  = dvs;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_nxt = (msum > (MAG_W+2)'(PROD_LIM)) ? PROD_LIM : msum[MAG_W-1:0];
        end
        default: begin
          acc_nxt = {acc_r[MAG_W-2:0], q_bit};
          rem_nxt = q_bit ? tdiff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
      endcase
      cnt_nxt = cnt_r - IDX_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    dvs_r <= dvs_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("unit done without a running operation");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && !done_r)
    else $error("unit started while busy");

  a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && op_r == OP_MUL |-> acc_r <= PROD_LIM)
    else $error("product above saturation limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && op_r == OP_DIV |-> rem_r < dvs_r)
    else $error("remainder not below divisor");

endmodule

### sim/pid_controller_two_derivative_tb.sv
module pid_controller_two_derivative_tb;

  localparam int SW        = 16;
  localparam int TW        = 48;
  localparam int WATCHDOG  = 40000;
  localparam int HOLD_LONG = 3000;
  localparam int TAIL      = 400;
  localparam logic [63:0] SAT_LIM = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TMASK   = (64'd1 << TW) - 64'd1;

  typedef enum logic [2:0] {
    REG_GAIN_PROP       = 3'd0,
    REG_GAIN_INTEGRAL   = 3'd1,
    REG_GAIN_ERR_DERIV  = 3'd2,
    REG_GAIN_MEAS_DERIV = 3'd3,
    REG_OUT_LOW         = 3'd4,
    REG_OUT_HIGH        = 3'd5,
    REG_MIN_CYCLE_MS    = 3'd6,
    REG_SMOOTHING       = 3'd7
  } reg_idx_t;

  typedef struct {
    logic signed [SW-1:0] drive;
    logic                 fresh;
  } drive_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] in_measured = '0;
  logic signed [SW-1:0] in_target = '0;
  logic [TW-1:0]        in_now_us = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] out_drive;
  logic                 out_fresh;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  pid_controller_two_derivative #(.SAMPLE_WIDTH(SW), .TIME_WIDTH(TW)) dut (.*);

  // Controller copy: configuration and loop state
  longint kp, ki, kd_err, kd_meas, lim_lo, lim_hi;
  longint unsigned min_ms, smooth;
  longint integ_acc, last_err, last_meas, last_delta, last_drive;
  longint unsigned last_time;
  bit     started;

  drive_word_t drive_q[$];
  int     errors = 0;
  int     n_items = 0, n_fresh = 0, n_words = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;
  int     hold_left = 0;
  int     idle_cycles = 0;
  logic [TW-1:0] cur_time;

  initial forever #6 clk = ~clk;

  // Fixed-point helpers
  function automatic longint unsigned magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned sat_mag(longint unsigned a, longint unsigned b);
    longint unsigned p;
    if (a != 0 && b > SAT_LIM / a) return SAT_LIM;
    p = a * b;
    return p > SAT_LIM ? SAT_LIM : p;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_mul(longint a, longint b);
    return signed_of(sat_mag(magn(a), magn(b)), (a < 0) != (b < 0));
  endfunction

  function automatic longint div_tz(longint x, longint unsigned d);
    if (d == 0) return 0;
    return signed_of(magn(x) / d, x < 0);
  endfunction

  // Advance the controller copy by one word and return the expected output
  function automatic drive_word_t pid_step(longint meas, longint tgt, longint unsigned now);
    drive_word_t r;
    longint unsigned dt;
    longint err, acc, kie, inc, integ, d8, drv;
    dt = (now - last_time) & TMASK;
    if (!(dt / 1000 > min_ms)) begin
      r.drive = last_drive[SW-1:0];
      r.fresh = 1'b0;
      return r;
    end
    err = tgt - meas;
    acc = sat_mul(kp, err);
    if (started) begin
      kie = sat_mul(ki, err);
      inc = signed_of(sat_mag(magn(kie), dt), kie < 0);
      integ = integ_acc + inc;
      if (integ > lim_hi * 65536) integ = lim_hi * 65536;
      if (integ < lim_lo * 65536) integ = lim_lo * 65536;
      integ_acc = integ;
      acc += integ;
      acc += div_tz(sat_mul(kd_err, err - last_err), dt);
      d8 = (meas - last_meas) * 256;
      if (smooth > 0)
        d8 = div_tz(last_delta * 256 + d8 * longint'(smooth), 256 + smooth);
      last_delta = d8;
      acc -= div_tz(div_tz(sat_mul(kd_meas, d8), dt), 256);
    end
    drv = acc >= 0 ? acc / 65536 : -longint'((magn(acc) + 65535) / 65536);
    if (drv > lim_hi) drv = lim_hi;
    if (drv < lim_lo) drv = lim_lo;
    last_err = err;
    last_meas = meas;
    last_drive = drv;
    last_time = now;
    started = 1'b1;
    r.drive = drv[SW-1:0];
    r.fresh = 1'b1;
    return r;
  endfunction

  function automatic int rand_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Send one word; leave valid high when no gap follows
  task automatic send_word(logic signed [SW-1:0] meas, logic signed [SW-1:0] tgt,
                           logic [TW-1:0] now);
    int gap;
    in_valid    <= 1'b1;
    in_measured <= meas;
    in_target   <= tgt;
    in_now_us   <= now;
    do @(posedge clk); while (!in_ready);
    drive_q.push_back(pid_step(meas, tgt, now));
    cur_time = now;
    n_items++;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every expected word to drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_PROP:       kp      = longint'($signed(val));
      REG_GAIN_INTEGRAL:   ki      = longint'($signed(val));
      REG_GAIN_ERR_DERIV:  kd_err  = longint'($signed(val));
      REG_GAIN_MEAS_DERIV: kd_meas = longint'($signed(val));
      REG_OUT_LOW:         lim_lo  = longint'($signed(val[SW-1:0]));
      REG_OUT_HIGH:        lim_hi  = longint'($signed(val[SW-1:0]));
      REG_MIN_CYCLE_MS:    min_ms  = val[15:0];
      REG_SMOOTHING:       smooth  = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] de, logic [31:0] dm,
                           logic [15:0] lo, logic [15:0] hi, logic [15:0] ms,
                           logic [15:0] sm);
    write_reg(REG_GAIN_PROP, p);
    write_reg(REG_GAIN_INTEGRAL, i);
    write_reg(REG_GAIN_ERR_DERIV, de);
    write_reg(REG_GAIN_MEAS_DERIV, dm);
    write_reg(REG_OUT_LOW, {16'h0, lo});
    write_reg(REG_OUT_HIGH, {16'h0, hi});
    write_reg(REG_MIN_CYCLE_MS, {16'h0, ms});
    write_reg(REG_SMOOTHING, {16'h0, sm});
  endtask

  // Pick a timestamp: repeat step, computed step, backwards, or anywhere
  function automatic logic [TW-1:0] pick_time();
    int r;
    longint unsigned t;
    r = $urandom_range(0, 99);
    if (r < 20)
      t = last_time + $urandom_range(0, int'(min_ms) * 1000 + 999);
    else if (r < 90)
      t = last_time + (min_ms + 1) * 1000 + $urandom_range(0, 4000);
    else if (r < 95)
      t = last_time - $urandom_range(1, 2000);
    else
      t = {$urandom, $urandom};
    return t[TW-1:0];
  endfunction

  function automatic logic [SW-1:0] pick_sample(logic [SW-1:0] near);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return near + SW'($urandom_range(0, 600)) - SW'(300);
    if (r == 5) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return SW'($urandom);
  endfunction

  task automatic reset_dut();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    kp = 0; ki = 0; kd_err = 0; kd_meas = 0;
    lim_lo = -32768; lim_hi = 32767; min_ms = 0; smooth = 0;
    integ_acc = 0; last_err = 0; last_meas = 0; last_delta = 0; last_drive = 0;
    last_time = 0; started = 1'b0; cur_time = '0;
    @(posedge clk);
  endtask

  // Reset configuration: first step, repeats, all-zero gains
  task automatic test_reset_defaults();
    send_word(16'sd100, 16'sd200, 48'd500);
    send_word(16'sd100, 16'sd200, 48'd1500);
    send_word(16'sd100, 16'sd200, 48'd1999);
    send_word(-16'sd5, 16'sd7, 48'd4000);
    drain();
  endtask

  // Field and gain extremes, saturation, wrapped time
  task automatic test_extremes();
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    send_word(16'sh8000, 16'sh7fff, 48'd10000);
    send_word(16'sh7fff, 16'sh8000, 48'd20000);
    send_word(16'sh8000, 16'sh8000, 48'hffff_ffff_ffff);
    send_word(16'sh7fff, 16'sh7fff, 48'd5000);
    send_word(16'sh0000, 16'sh7fff, 48'd5500);
    drain();
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              16'hff00, 16'h0100, 16'hffff, 16'h0001);
    send_word(16'sh7fff, 16'sh8000, cur_time + 48'd1000);
    send_word(16'sh1234, 16'sh4321, cur_time + 48'd65536000);
    send_word(16'sh8000, 16'sh0000, cur_time + 48'd65536999);
    send_word(-16'sd1, 16'sd1, cur_time + 48'd65535999);
    drain();
  endtask

  // Low limit above high limit: the low limit governs output and integral
  task automatic test_inverted_limits();
    write_all(32'h00010000, 32'h00000040, 32'h00100000, 32'h00080000,
              16'sd500, -16'sd500, 16'd2, 16'h0080);
    send_word(16'sd0, 16'sd1000, cur_time + 48'd3000);
    send_word(16'sd100, -16'sd1000, cur_time + 48'd3000);
    send_word(16'sd300, 16'sd300, cur_time + 48'd2999);
    send_word(-16'sd300, 16'sd30, cur_time + 48'd7000);
    drain();
  endtask

  // Several random configurations with mostly well-formed timing
  task automatic test_random_phases();
    logic [SW-1:0] tg, ms;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_GAIN_PROP, $urandom_range(0, 3) == 0 ? $urandom :
                32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)));
      write_reg(REG_GAIN_INTEGRAL, $urandom_range(0, 3) == 0 ? $urandom :
                32'($signed($urandom_range(0, 256)) - 128));
      write_reg(REG_GAIN_ERR_DERIV, $urandom_range(0, 3) == 0 ? $urandom :
                32'($signed($urandom_range(0, 1 << 30)) - (1 << 29)));
      write_reg(REG_GAIN_MEAS_DERIV, $urandom_range(0, 3) == 0 ? $urandom :
                32'($signed($urandom_range(0, 1 << 30)) - (1 << 29)));
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_OUT_LOW, $urandom);
        write_reg(REG_OUT_HIGH, $urandom);
      end else begin
        write_reg(REG_OUT_LOW, 32'($signed(-$urandom_range(0, 32768))));
        write_reg(REG_OUT_HIGH, $urandom_range(0, 32767));
      end
      write_reg(REG_MIN_CYCLE_MS, ph == 3 ? 32'hffff : $urandom_range(0, 5));
      write_reg(REG_SMOOTHING, ph == 2 ? 0 : ph == 4 ? 32'hffff : $urandom);
      quiet = (ph == 5);
      tg = SW'($urandom);
      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(0, 15) == 0) tg = SW'($urandom);
        ms = pick_sample(tg);
        send_word(ms, pick_sample(tg), pick_time());
      end
      quiet = 1'b0;
      drain();
    end
  endtask

  // Hold the result side off long enough to back up the input
  task automatic test_backpressure();
    write_reg(REG_MIN_CYCLE_MS, 0);
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++)
      send_word(SW'($urandom), SW'($urandom),
                cur_time + 48'd1000 + TW'($urandom_range(0, 3000)));
    drain();
  endtask

  initial begin
    reset_dut();
    test_reset_defaults();
    test_extremes();
    test_inverted_limits();
    test_random_phases();
    test_backpressure();
    repeat (TAIL) @(posedge clk);
    $display("Covered %0d words (%0d computed), reset, extremes, inverted limits,", n_items,
             n_fresh);
    $display("random phases and a long output stall; %0d mismatches", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Drive out_ready: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_LONG;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  out_ready <= 1'b1;
        [70:96]: out_ready <= 1'b0;
        default: begin
          hold_left <= $urandom_range(20, 200);
          out_ready <= 1'b0;
        end
      endcase
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    drive_word_t w;
    if (rst_n && out_valid && out_ready) begin
      n_words++;
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: drive %0d fresh %0b", out_drive, out_fresh);
      end else begin
        w = drive_q.pop_front();
        if (w.fresh) n_fresh++;
        if (out_drive !== w.drive || out_fresh !== w.fresh) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected drive %0d fresh %0b, got drive %0d fresh %0b",
                     w.drive, w.fresh, out_drive, out_fresh);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d words outstanding", drive_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
src/pidtd_pkg.sv
src/pidtd_unit.sv
src/pid_controller_two_derivative.sv
sim/pid_controller_two_derivative_tb.sv
